[src/utf8_sanitize_truncate_core_macros.svh]
// assertion helpers shared by the rtl files
`ifndef UTF8_SANITIZE_TRUNCATE_CORE_MACROS_SVH
`define UTF8_SANITIZE_TRUNCATE_CORE_MACROS_SVH

// checked on every rising edge outside reset
`define UTF8ST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define UTF8ST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/utf8st_pkg.sv]
`timescale 1ns / 1ps
package utf8st_pkg;

  localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;
  localparam logic [7:0]  REPLACE_CHAR    = 8'h3F;
  localparam int          QUEUE_DEPTH     = 4;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] width;  // sequence length when used as lead, 0 if it cannot lead
    logic       cont;   // 10xxxxxx
  } item_t;

  function automatic logic [2:0] lead_width(input logic [7:0] b);
    logic [2:0] w;
    w = 3'd0;
    if (b[7] == 1'b0) begin
      w = 3'd1;
    end else if (b[7:5] == 3'b110 && b >= 8'hC2) begin
      w = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      w = 3'd3;
    end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
      w = 3'd4;
    end
    return w;
  endfunction

endpackage

[src/utf8st_front.sv]
`timescale 1ns / 1ps
module utf8st_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] in_byte
  input  logic                s_tlast,
  input  logic                q_full,
  output logic                q_push,
  output utf8st_pkg::item_t   q_item
);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_item.data  = s_tdata;
    q_item.last  = s_tlast;
    q_item.width = utf8st_pkg::lead_width(s_tdata);
    q_item.cont  = (s_tdata[7:6] == 2'b10);
  end

endmodule

[src/utf8st_queue.sv]
`timescale 1ns / 1ps
`include "utf8_sanitize_truncate_core_macros.svh"
module utf8st_queue #(
  parameter int DEPTH = utf8st_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utf8st_pkg::item_t  push_item,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop_ready,
  output utf8st_pkg::item_t  pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utf8st_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `UTF8ST_ASSERT(a_count_bound, count <= FULL_CNT, "queue count beyond depth")

endmodule

[src/utf8st_back.sv]
`timescale 1ns / 1ps
`include "utf8_sanitize_truncate_core_macros.svh"
module utf8st_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  output logic               q_ready,
  input  utf8st_pkg::item_t  q_item,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // [7:0] out_byte, [8] truncated, rest zero
  output logic               m_tuser,   // has_byte
  output logic               m_tlast    // string_done
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINAL} state_t;
  typedef enum logic [2:0] {
    ACT_WAIT, ACT_FLUSH, ACT_PEND, ACT_STOP, ACT_REPL, ACT_SEQ, ACT_TAIL
  } act_t;

  state_t             state;
  utf8st_pkg::item_t  buf_q  [4];
  utf8st_pkg::item_t  pend_q [3];
  logic [1:0]         pcount;
  logic [2:0]         n_q;
  logic [2:0]         pos_q;
  logic [1:0]         run_left;
  logic               last_q;
  logic [15:0]        emitted;
  logic               trunc_seen;
  logic               stopped;
  logic [15:0]        max_bytes;
  logic               hold_valid;
  logic [7:0]         hold_byte;
  logic               o_valid;
  logic [7:0]         o_byte;
  logic               o_has;
  logic               o_done;
  logic               o_trunc;

  utf8st_pkg::item_t  cur;
  utf8st_pkg::item_t  win1;
  utf8st_pkg::item_t  win2;
  utf8st_pkg::item_t  win3;
  logic [1:0]         idx1;
  logic [1:0]         idx2;
  logic [1:0]         idx3;
  logic [2:0]         rem;
  logic               fits;
  logic               seq_ok;
  logic               bad;
  logic [2:0]         need;
  logic               over;
  logic               out_free;
  logic               emit_ok;
  act_t               act;
  logic               prod;
  logic [7:0]         prod_byte;
  logic               o_load;

  assign cfg_ready = 1'b1;
  assign q_ready   = (state == S_IDLE);
  assign m_tvalid  = o_valid;
  assign m_tdata   = {7'd0, o_trunc, o_byte};
  assign m_tuser   = o_has;
  assign m_tlast   = o_done;

  assign out_free = !o_valid || m_tready;
  // on the final byte results go through the hold slot so the last one can be marked
  assign emit_ok  = last_q ? (!hold_valid || out_free) : out_free;

  always_comb begin
    idx1 = pos_q[1:0] + 2'd1;
    idx2 = pos_q[1:0] + 2'd2;
    idx3 = pos_q[1:0] + 2'd3;
    cur  = buf_q[pos_q[1:0]];
    win1 = buf_q[idx1];
    win2 = buf_q[idx2];
    win3 = buf_q[idx3];
    rem  = n_q - pos_q;
    fits = (cur.width <= rem);

    case (cur.width)
      3'd1: seq_ok = 1'b1;
      3'd2: seq_ok = win1.cont;
      3'd3: seq_ok = win1.cont && win2.cont
                  && !(cur.data == 8'hE0 && win1.data < 8'hA0)
                  && !(cur.data == 8'hED && win1.data >= 8'hA0);
      3'd4: seq_ok = win1.cont && win2.cont && win3.cont
                  && !(cur.data == 8'hF0 && win1.data < 8'h90)
                  && !(cur.data == 8'hF4 && win1.data >= 8'h90);
      default: seq_ok = 1'b0;
    endcase

    bad  = (cur.width == 3'd0) || !fits || !seq_ok;
    need = bad ? 3'd1 : cur.width;
    over = ({1'b0, emitted} + 17'(need)) > {1'b0, max_bytes};

    act = ACT_WAIT;
    if (state == S_RUN) begin
      if (run_left != 2'd0) begin
        act = emit_ok ? ACT_TAIL : ACT_WAIT;
      end else if (rem == 3'd0) begin
        act = ACT_FLUSH;
      end else if (cur.width != 3'd0 && !fits && !last_q) begin
        act = ACT_PEND;
      end else if (over) begin
        act = ACT_STOP;
      end else if (emit_ok) begin
        act = bad ? ACT_REPL : ACT_SEQ;
      end
    end

    prod      = (act == ACT_TAIL) || (act == ACT_REPL) || (act == ACT_SEQ);
    prod_byte = (act == ACT_REPL) ? utf8st_pkg::REPLACE_CHAR : cur.data;
    // output register takes a new transaction this cycle
    o_load    = (prod && (!last_q || hold_valid)) || (state == S_FINAL && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pcount     <= 2'd0;
      n_q        <= 3'd0;
      pos_q      <= 3'd0;
      run_left   <= 2'd0;
      last_q     <= 1'b0;
      emitted    <= 16'd0;
      trunc_seen <= 1'b0;
      stopped    <= 1'b0;
      max_bytes  <= utf8st_pkg::MAX_BYTES_RESET;
      hold_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (o_valid && m_tready && !o_load) begin
        o_valid <= 1'b0;
      end
      if (cfg_valid) begin
        max_bytes <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (q_valid) begin
            last_q   <= q_item.last;
            pos_q    <= 3'd0;
            run_left <= 2'd0;
            // after a budget stop the rest of the string is dropped
            if (stopped) begin
              n_q <= 3'd0;
            end else begin
              n_q <= {1'b0, pcount} + 3'd1;
              for (int i = 0; i < 3; i++) begin
                buf_q[i] <= (2'(i) < pcount) ? pend_q[i] : q_item;
              end
              buf_q[3] <= q_item;
            end
            state <= S_RUN;
          end
        end
        S_RUN: begin
          case (act)
            ACT_TAIL: begin
              pos_q    <= pos_q + 3'd1;
              run_left <= run_left - 2'd1;
            end
            ACT_FLUSH: begin
              pcount <= 2'd0;
              state  <= last_q ? S_FINAL : S_IDLE;
            end
            ACT_PEND: begin
              // sequence still open: keep its bytes for the next transaction
              for (int j = 0; j < 3; j++) begin
                pend_q[j] <= buf_q[pos_q[1:0] + 2'(j)];
              end
              pcount <= rem[1:0];
              state  <= S_IDLE;
            end
            ACT_STOP: begin
              stopped    <= 1'b1;
              trunc_seen <= 1'b1;
              pcount     <= 2'd0;
              state      <= last_q ? S_FINAL : S_IDLE;
            end
            ACT_REPL: begin
              trunc_seen <= 1'b1;
              emitted    <= emitted + 16'd1;
              pos_q      <= pos_q + 3'd1;
            end
            ACT_SEQ: begin
              emitted  <= emitted + 16'(cur.width);
              pos_q    <= pos_q + 3'd1;
              run_left <= 2'(cur.width - 3'd1);
            end
            default: begin
            end
          endcase
        end
        S_FINAL: begin
          if (out_free) begin
            o_valid    <= 1'b1;
            o_byte     <= hold_valid ? hold_byte : 8'd0;
            o_has      <= hold_valid;
            o_done     <= 1'b1;
            o_trunc    <= trunc_seen;
            hold_valid <= 1'b0;
            emitted    <= 16'd0;
            trunc_seen <= 1'b0;
            stopped    <= 1'b0;
            pcount     <= 2'd0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (prod) begin
        if (!last_q) begin
          o_valid <= 1'b1;
          o_byte  <= prod_byte;
          o_has   <= 1'b1;
          o_done  <= 1'b0;
          o_trunc <= 1'b0;
        end else begin
          if (hold_valid) begin
            o_valid <= 1'b1;
            o_byte  <= hold_byte;
            o_has   <= 1'b1;
            o_done  <= 1'b0;
            o_trunc <= 1'b0;
          end
          hold_valid <= 1'b1;
          hold_byte  <= prod_byte;
        end
      end
    end
  end

  `UTF8ST_ASSERT(a_pos_in_buf, pos_q <= n_q, "scan position past buffered bytes")
  `UTF8ST_ASSERT(a_stop_marks_trunc, stopped |-> trunc_seen, "budget stop without truncated flag")
  `UTF8ST_ASSERT(a_stop_no_pending, (stopped && state == S_IDLE) |-> (pcount == 2'd0),
                 "bytes kept after budget stop")

endmodule

[src/utf8_sanitize_truncate_core.sv]
`timescale 1ns / 1ps
// UTF-8 sanitizer with an output budget. Bytes of a string enter on s_* (tlast marks the
// final byte); valid sequences leave unchanged on m_*, every invalid position (bad lead,
// missing continuation, overlong, surrogate, above U+10FFFF, or cut off by the end of the
// string) becomes one '?', and output for the string stops once the next piece would exceed
// max_bytes (cfg_* port, reset 1024). The last result of each string has tlast set and
// carries the truncated flag; it is status only (tuser low) when no byte goes with it.
// A front end classifies bytes into a queue of QUEUE_DEPTH entries; the back end sequencer
// handles one buffered position per cycle while the output is free, so an input byte costs
// more per result, and a string end adds a final step. The queue soaks up those bursts.
module utf8_sanitize_truncate_core #(
  parameter int QUEUE_DEPTH = utf8st_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] truncated, rest zero
  output logic        m_tuser,   // has_byte
  output logic        m_tlast
);

  utf8st_pkg::item_t push_item;
  utf8st_pkg::item_t pop_item;
  logic              q_full;
  logic              q_push;
  logic              q_valid;
  logic              q_ready;

  utf8st_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  utf8st_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (pop_item)
  );

  utf8st_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[tb/utf8_sanitize_truncate_core_test.sv]
`timescale 1ns / 1ps
module utf8_sanitize_truncate_core_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT      = 12;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic       truncated;
  } sanitized_t;

  typedef enum int {
    PIECE_ASCII, PIECE_TWO, PIECE_THREE, PIECE_FOUR,
    PIECE_BAD_LEAD, PIECE_LONE_CONT, PIECE_OVERLONG, PIECE_SURROGATE,
    PIECE_ABOVE_MAX, PIECE_MISSING_CONT, PIECE_CUT_SHORT, PIECE_NOISE
  } piece_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] out_byte, [8] truncated
  logic        m_tuser;   // has_byte
  logic        m_tlast;

  // predictor state
  logic [15:0] max_budget;
  logic [7:0]  held [0:2];
  int          held_cnt;
  int          emitted;
  bit          trunc_seen;
  bit          stopped;

  sanitized_t  sanitized_q [$];
  logic [7:0]  str_bytes [$];
  sanitized_t  want;
  int          mismatch_count;
  int          cycle_count;
  bit          no_gaps;

  utf8_sanitize_truncate_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf8_sanitize_truncate_core: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sanitized_q.size() == 0) begin
        $error("output transaction with nothing expected: tdata=%h tuser=%b tlast=%b",
               m_tdata, m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        want = sanitized_q.pop_front();
        if (m_tdata[7:0] !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tuser !== want.has_byte) begin
          $error("has_byte: expected %b, actual %b", want.has_byte, m_tuser);
          mismatch_count++;
        end
        if (m_tlast !== want.string_done) begin
          $error("string_done: expected %b, actual %b", want.string_done, m_tlast);
          mismatch_count++;
        end
        if (m_tdata[8] !== want.truncated) begin
          $error("truncated: expected %b, actual %b", want.truncated, m_tdata[8]);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int lead_len(input logic [7:0] f);
    case (f) inside
      8'b0???????: return 1;
      8'b110?????: return (f < 8'hC2) ? 0 : 2;
      8'b1110????: return 3;
      8'b11110???: return (f > 8'hF4) ? 0 : 4;
      default:     return 0;
    endcase
  endfunction

  function automatic bit seq_ok(input logic [7:0] b0, b1, b2, b3, input int w);
    logic [7:0] tail [1:3];
    int cp;
    tail[1] = b1;
    tail[2] = b2;
    tail[3] = b3;
    if (w == 1) return 1'b1;
    cp = (w == 2) ? int'(b0[4:0]) : (w == 3) ? int'(b0[3:0]) : int'(b0[2:0]);
    for (int i = 1; i < w; i++) begin
      if (tail[i][7:6] != 2'b10) return 1'b0;
      cp = (cp << 6) | int'(tail[i][5:0]);
    end
    if (w == 2 && cp < 'h80) return 1'b0;
    if (w == 3 && cp < 'h800) return 1'b0;
    if (w == 4 && cp < 'h10000) return 1'b0;
    if (cp >= 'hD800 && cp <= 'hDFFF) return 1'b0;
    return cp <= 'h10FFFF;
  endfunction

  task automatic add_str_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endtask

  task automatic predict_sanitized(input logic [7:0] in_b, input logic last);
    logic [7:0] win [0:6];
    sanitized_t outs [0:3];
    int n;
    int pos;
    int w;
    int k;
    bit ok;
    for (int i = 0; i < 7; i++) win[i] = 8'h00;
    n = 0;
    pos = 0;
    k = 0;
    if (!stopped) begin
      for (int i = 0; i < held_cnt; i++) begin
        win[n] = held[i];
        n++;
      end
      win[n] = in_b;
      n++;
    end
    while (pos < n && !stopped) begin
      w = lead_len(win[pos]);
      if (w == 0) begin
        ok = 1'b0;
      end else if (pos + w > n) begin
        // incomplete sequence waits for more bytes unless the string ends here
        if (!last) break;
        ok = 1'b0;
      end else begin
        ok = seq_ok(win[pos], win[pos + 1], win[pos + 2], win[pos + 3], w);
      end
      if (!ok) begin
        trunc_seen = 1'b1;
        if (emitted + 1 > int'(max_budget)) begin
          stopped = 1'b1;
          break;
        end
        outs[k] = {utf8st_pkg::REPLACE_CHAR, 3'b100};
        k++;
        emitted++;
        pos++;
      end else begin
        if (emitted + w > int'(max_budget)) begin
          trunc_seen = 1'b1;
          stopped = 1'b1;
          break;
        end
        for (int i = 0; i < w; i++) begin
          outs[k] = {win[pos + i], 3'b100};
          k++;
        end
        emitted += w;
        pos += w;
      end
    end
    held_cnt = 0;
    if (!stopped) begin
      while (pos < n && held_cnt < 3) begin
        held[held_cnt] = win[pos];
        held_cnt++;
        pos++;
      end
    end
    if (last) begin
      // status-only close when nothing goes out with the final byte
      if (k == 0) begin
        outs[0] = {8'h00, 3'b000};
        k = 1;
      end
      outs[k - 1].string_done = 1'b1;
      outs[k - 1].truncated = trunc_seen;
      held_cnt = 0;
      emitted = 0;
      trunc_seen = 1'b0;
      stopped = 1'b0;
    end
    for (int i = 0; i < k; i++) sanitized_q.insert(sanitized_q.size(), outs[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_sanitized(b, last);
    @(negedge clk);
  endtask

  task automatic send_string();
    int n;
    n = str_bytes.size();
    for (int i = 0; i < n; i++) send_byte(str_bytes[i], i == n - 1);
    str_bytes.delete();
  endtask

  // block may still chew on bytes that produce nothing, so settle after the drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sanitized_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_budget(input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_budget = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic append_cp(input int cp, input int w);
    logic [20:0] v;
    v = cp[20:0];
    case (w)
      1: add_str_byte(v[7:0]);
      2: begin
        add_str_byte({3'b110, v[10:6]});
        add_str_byte({2'b10, v[5:0]});
      end
      3: begin
        add_str_byte({4'b1110, v[15:12]});
        add_str_byte({2'b10, v[11:6]});
        add_str_byte({2'b10, v[5:0]});
      end
      default: begin
        add_str_byte({5'b11110, v[20:18]});
        add_str_byte({2'b10, v[17:12]});
        add_str_byte({2'b10, v[11:6]});
        add_str_byte({2'b10, v[5:0]});
      end
    endcase
  endtask

  function automatic int valid_cp(input int w);
    int cp;
    case (w)
      1: cp = $urandom_range('h7F);
      2: cp = $urandom_range('h7FF, 'h80);
      3: begin
        cp = $urandom_range('hFFFF, 'h800);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
      end
      default: cp = $urandom_range('h10FFFF, 'h10000);
    endcase
    return cp;
  endfunction

  task automatic append_piece(input piece_kind_t kind);
    int w;
    int idx;
    logic [7:0] b;
    w = $urandom_range(4, 2);
    case (kind)
      PIECE_ASCII: append_cp(valid_cp(1), 1);
      PIECE_TWO:   append_cp(valid_cp(2), 2);
      PIECE_THREE: append_cp(valid_cp(3), 3);
      PIECE_FOUR:  append_cp(valid_cp(4), 4);
      PIECE_BAD_LEAD: begin
        idx = $urandom_range(12);
        add_str_byte((idx < 2) ? 8'(8'hC0 + idx) : 8'(8'hF5 + (idx - 2)));
      end
      PIECE_LONE_CONT: add_str_byte(8'($urandom_range(8'hBF, 8'h80)));
      PIECE_OVERLONG:
        append_cp($urandom_range((w == 2) ? 'h7F : (w == 3) ? 'h7FF : 'hFFFF), w);
      PIECE_SURROGATE: append_cp($urandom_range('hDFFF, 'hD800), 3);
      PIECE_ABOVE_MAX: append_cp($urandom_range('h1FFFFF, 'h110000), 4);
      PIECE_MISSING_CONT: begin
        append_cp(valid_cp(w), w);
        idx = str_bytes.size() - 1 - $urandom_range(w - 2);
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        str_bytes[idx] = b;
      end
      PIECE_CUT_SHORT: begin
        append_cp(valid_cp(w), w);
        repeat ($urandom_range(w - 1, 1)) void'(str_bytes.pop_back());
      end
      default: add_str_byte(8'($urandom_range(255)));
    endcase
  endtask

  // mostly well-formed text with some broken pieces mixed in
  task automatic test_random_text(input logic [15:0] budget, input int n_items);
    int sent;
    piece_kind_t kind;
    write_budget(budget);
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(8, 1)) begin
        if ($urandom_range(99) < 75) kind = piece_kind_t'(int'(PIECE_ASCII) + $urandom_range(3));
        else kind = piece_kind_t'(int'(PIECE_BAD_LEAD) + $urandom_range(7));
        append_piece(kind);
      end
      sent += str_bytes.size();
      send_string();
    end
  endtask

  // runs on the reset budget: both ends of the one-byte range, top of the two- and four-byte ranges
  task automatic test_valid_forms();
    str_bytes = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
  endtask

  // bad lead, surrogate, above max, missing continuation, cut short at end
  task automatic test_invalid_forms();
    str_bytes = '{8'hC1, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                  8'hC3, 8'hFF, 8'hE2, 8'h82};
    send_string();
  endtask

  task automatic test_zero_budget();
    write_budget(16'h0000);
    str_bytes = '{8'h41};
    send_string();
  endtask

  // the euro sign does not fit, the trailing byte is then ignored
  task automatic test_budget_stop();
    write_budget(16'd3);
    str_bytes = '{8'h41, 8'hE2, 8'h82, 8'hAC, 8'h42};
    send_string();
  endtask

  // budget drops below the bytes already sent while a sequence is held
  task automatic test_budget_midstring();
    write_budget(16'hFFFF);
    repeat (5) send_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    write_budget(16'd2);
    send_byte(8'hAC, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_small_budgets();
    repeat (6) test_random_text(16'($urandom_range(16)), 20);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    test_random_text(16'($urandom_range(16'hFFFF)), 100);
    wait_idle();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = 16'h0000;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    no_gaps    = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    max_budget = utf8st_pkg::MAX_BYTES_RESET;
    held_cnt   = 0;
    emitted    = 0;
    trunc_seen = 1'b0;
    stopped    = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_valid_forms();
    test_invalid_forms();
    test_zero_budget();
    test_budget_stop();
    test_random_text(16'hFFFF, 90);
    test_small_budgets();
    test_budget_midstring();
    test_back_to_back();
    test_random_text(utf8st_pkg::MAX_BYTES_RESET, 80);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("utf8_sanitize_truncate_core: match");
    end else begin
      $display("utf8_sanitize_truncate_core: mismatch");
    end
    $finish;
  end

endmodule
